### design/ycbcr422_to_rgb_converter_top_assert.svh
// Assertion macros shared by the checker of the colour converter.
`ifndef YCBCR422_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define YCBCR422_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define YCRGB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Checked on every clock edge, reset included.
`define YCRGB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

### design/ycrgb_pkg.sv
// Package: coefficients, widths and types of the 4:2:2 YCbCr to RGB converter.
`timescale 1ns / 1ps

package ycrgb_pkg;

    localparam int PIX_W      = 8;
    localparam int FRAC_BITS  = 14;
    localparam int DIFF_W     = PIX_W + 1;          // chroma minus mid point
    localparam int COEF_W     = 16;                 // Q1.14 plus sign bit
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int ACC_W      = 25;

    localparam logic signed [COEF_W-1:0] COEF_R_CR = 16'sd23061;
    localparam logic signed [COEF_W-1:0] COEF_G_CB = 16'sd5661;
    localparam logic signed [COEF_W-1:0] COEF_G_CR = 16'sd11746;
    localparam logic signed [COEF_W-1:0] COEF_B_CB = 16'sd29147;
    localparam logic [PIX_W-1:0]         CHROMA_MID = 8'd128;
    localparam logic [PIX_W-1:0]         PIX_MAX    = 8'd255;

    typedef struct packed {
        logic signed [PROD_W-1:0] r_cr;
        logic signed [PROD_W-1:0] g_cb;
        logic signed [PROD_W-1:0] g_cr;
        logic signed [PROD_W-1:0] b_cb;
    } chroma_terms_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    // Floor of a Q.14 sum, clamped to the pixel range.
    function automatic logic [PIX_W-1:0] clamp_q14(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_BITS-1:0] whole;
        whole = acc[ACC_W-1:FRAC_BITS];
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (|whole[ACC_W-FRAC_BITS-2:PIX_W]) begin
            return PIX_MAX;
        end else begin
            return whole[PIX_W-1:0];
        end
    endfunction

endpackage

### design/ycrgb_chroma.sv
// Shared chroma products, one registered multiplier per coefficient.
`timescale 1ns / 1ps

module ycrgb_chroma
    import ycrgb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      load,
    input  logic signed [DIFF_W-1:0]  diff_cb,
    input  logic signed [DIFF_W-1:0]  diff_cr,
    output chroma_terms_t             terms
);

    chroma_terms_t terms_reg;
    chroma_terms_t terms_next;

    always_comb begin
        terms_next.r_cr = COEF_R_CR * diff_cr;
        terms_next.g_cb = COEF_G_CB * diff_cb;
        terms_next.g_cr = COEF_G_CR * diff_cr;
        terms_next.b_cb = COEF_B_CB * diff_cb;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

### design/ycrgb_lane.sv
// One pixel lane: luma plus chroma terms, floored and clamped per channel.
`timescale 1ns / 1ps

module ycrgb_lane
    import ycrgb_pkg::*;
(
    input  logic [PIX_W-1:0] luma,
    input  chroma_terms_t    terms,
    output rgb_pixel_t       pixel
);

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_r;
    logic signed [ACC_W-1:0] acc_g;
    logic signed [ACC_W-1:0] acc_b;

    assign base  = signed'({{(ACC_W-PIX_W-FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});
    assign acc_r = base + ACC_W'(terms.r_cr);
    assign acc_g = base - ACC_W'(terms.g_cb) - ACC_W'(terms.g_cr);
    assign acc_b = base + ACC_W'(terms.b_cb);

    assign pixel.red   = clamp_q14(acc_r);
    assign pixel.green = clamp_q14(acc_g);
    assign pixel.blue  = clamp_q14(acc_b);

endmodule

### design/ycbcr422_to_rgb_converter_top.sv
// A request passes the input, product and output registers before its result is valid.
// Throughput: one pixel pair per cycle while m_ready holds; each stage refills as it drains, so bubbles collapse.
// The four chroma multipliers are shared by both pixel lanes, one pair per clock unless the output stalls.
// Reset (aresetn low, synchronous) empties all stages; payload registers are not cleared.
`timescale 1ns / 1ps

module ycbcr422_to_rgb_converter_top
    import ycrgb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_luma_first,
    input  logic [PIX_W-1:0] s_luma_second,
    input  logic [PIX_W-1:0] s_chroma_blue,
    input  logic [PIX_W-1:0] s_chroma_red,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_red_first,
    output logic [PIX_W-1:0] m_green_first,
    output logic [PIX_W-1:0] m_blue_first,
    output logic [PIX_W-1:0] m_red_second,
    output logic [PIX_W-1:0] m_green_second,
    output logic [PIX_W-1:0] m_blue_second
);

    logic in_valid_reg, in_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_en, prod_en, in_en;

    logic [PIX_W-1:0]         in_y0_reg, in_y1_reg;
    logic signed [DIFF_W-1:0] in_db_reg, in_dr_reg;
    logic [PIX_W-1:0]         prod_y0_reg, prod_y1_reg;

    chroma_terms_t terms;
    rgb_pixel_t    lane_pix [2];
    rgb_pixel_t    out_first_reg, out_second_reg;

    // Each stage may load when empty or when its contents move on.
    assign out_en  = !out_valid_reg || m_ready;
    assign prod_en = !prod_valid_reg || out_en;
    assign in_en   = !in_valid_reg || prod_en;
    assign s_ready = in_en;

    always_comb begin
        in_valid_next   = in_en   ? s_valid        : in_valid_reg;
        prod_valid_next = prod_en ? in_valid_reg   : prod_valid_reg;
        out_valid_next  = out_en  ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            in_y0_reg <= s_luma_first;
            in_y1_reg <= s_luma_second;
            in_db_reg <= signed'({1'b0, s_chroma_blue}) - signed'({1'b0, CHROMA_MID});
            in_dr_reg <= signed'({1'b0, s_chroma_red}) - signed'({1'b0, CHROMA_MID});
        end
        if (prod_en && in_valid_reg) begin
            prod_y0_reg <= in_y0_reg;
            prod_y1_reg <= in_y1_reg;
        end
        if (out_en && prod_valid_reg) begin
            out_first_reg  <= lane_pix[0];
            out_second_reg <= lane_pix[1];
        end
    end

    ycrgb_chroma u_chroma (
        .aclk    (aclk),
        .load    (prod_en && in_valid_reg),
        .diff_cb (in_db_reg),
        .diff_cr (in_dr_reg),
        .terms   (terms)
    );

    ycrgb_lane u_lane_first (
        .luma  (prod_y0_reg),
        .terms (terms),
        .pixel (lane_pix[0])
    );

    ycrgb_lane u_lane_second (
        .luma  (prod_y1_reg),
        .terms (terms),
        .pixel (lane_pix[1])
    );

    assign m_valid        = out_valid_reg;
    assign m_red_first    = out_first_reg.red;
    assign m_green_first  = out_first_reg.green;
    assign m_blue_first   = out_first_reg.blue;
    assign m_red_second   = out_second_reg.red;
    assign m_green_second = out_second_reg.green;
    assign m_blue_second  = out_second_reg.blue;

endmodule

### design/ycrgb_checker.sv
// Port-level checks on the converter, bound to the top level.
`timescale 1ns / 1ps
`include "ycbcr422_to_rgb_converter_top_assert.svh"

module ycrgb_checker
    import ycrgb_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [PIX_W-1:0] m_red_first,
    input logic [PIX_W-1:0] m_green_first,
    input logic [PIX_W-1:0] m_blue_first,
    input logic [PIX_W-1:0] m_red_second,
    input logic [PIX_W-1:0] m_green_second,
    input logic [PIX_W-1:0] m_blue_second
);

    logic [6*PIX_W-1:0] result_bus;
    assign result_bus = {m_red_first, m_green_first, m_blue_first,
                         m_red_second, m_green_second, m_blue_second};

    // No result straight out of reset.
    `YCRGB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
    // A stalled result stays valid and unchanged.
    `YCRGB_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `YCRGB_ASSERT(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(result_bus))
    // With the output side free, a new request is always taken.
    `YCRGB_ASSERT(a_no_stall, aclk, aresetn, (!m_valid || m_ready) |-> s_ready)

endmodule

bind ycbcr422_to_rgb_converter_top ycrgb_checker u_ycrgb_checker (.*);

### verif/ycbcr422_to_rgb_converter_top_tb.sv
// Self-checking testbench of the 4:2:2 YCbCr to RGB888 colour converter.
`timescale 1ns / 1ps

module ycbcr422_to_rgb_converter_top_tb;
    import ycrgb_pkg::*;

    // Q.14 chroma weights of the conversion
    localparam int Q_FRAC    = 14;
    localparam int K_RED_CR  = 23061;
    localparam int K_GRN_CB  = 5661;
    localparam int K_GRN_CR  = 11746;
    localparam int K_BLU_CB  = 29147;
    localparam int MID_LEVEL = 128;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 80;
    localparam int STUCK_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        rgb_pixel_t first;
        rgb_pixel_t second;
    } rgb_pair_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        bit         typed;      // expectation written out in the row
        rgb_pair_t  rgb;
    } pair_row_t;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_luma_first   = '0;
    logic [7:0] s_luma_second  = '0;
    logic [7:0] s_chroma_blue  = '0;
    logic [7:0] s_chroma_red   = '0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_red_first;
    logic [7:0] m_green_first;
    logic [7:0] m_blue_first;
    logic [7:0] m_red_second;
    logic [7:0] m_green_second;
    logic [7:0] m_blue_second;

    // Typed expectation travelling with the request on offer
    bit         cur_typed      = 1'b0;
    rgb_pair_t  cur_rgb        = '0;

    rgb_pair_t  rgb_expect_q[$];
    int         err_count      = 0;
    int         stuck_cycles   = 0;
    bit         idle_on        = 1'b1;
    bit         hold_req       = 1'b0;

    logic [7:0] edge_levels[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};

    // Neutral chroma gives grey, so those rows carry their answer directly
    pair_row_t  pair_table[] = '{
        '{8'd0,   8'd0,   8'd128, 8'd128, 1'b1, 48'h000000_000000},
        '{8'd255, 8'd255, 8'd128, 8'd128, 1'b1, 48'hFFFFFF_FFFFFF},
        '{8'd0,   8'd255, 8'd128, 8'd128, 1'b1, 48'h000000_FFFFFF},
        '{8'd128, 8'd77,  8'd128, 8'd128, 1'b1, 48'h808080_4D4D4D},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, '0},
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 8'd128, 1'b0, '0},
        '{8'd0,   8'd0,   8'd128, 8'd255, 1'b0, '0},
        '{8'd128, 8'd128, 8'd0,   8'd128, 1'b0, '0},
        '{8'd128, 8'd128, 8'd128, 8'd0,   1'b0, '0},
        '{8'd1,   8'd254, 8'd129, 8'd127, 1'b0, '0},
        '{8'd200, 8'd16,  8'd127, 8'd129, 1'b0, '0},
        '{8'd170, 8'd85,  8'd170, 8'd85,  1'b0, '0},
        '{8'd85,  8'd170, 8'd85,  8'd170, 1'b0, '0},
        '{8'd255, 8'd0,   8'd1,   8'd254, 1'b0, '0}
    };

    ycbcr422_to_rgb_converter_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_luma_first   (s_luma_first),
        .s_luma_second  (s_luma_second),
        .s_chroma_blue  (s_chroma_blue),
        .s_chroma_red   (s_chroma_red),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_first    (m_red_first),
        .m_green_first  (m_green_first),
        .m_blue_first   (m_blue_first),
        .m_red_second   (m_red_second),
        .m_green_second (m_green_second),
        .m_blue_second  (m_blue_second)
    );

    // Floor of a Q.14 sum (arithmetic shift), saturated to a byte
    function automatic logic [7:0] floor_to_byte(input int sum);
        int whole;
        if (sum < 0) begin
            return 8'd0;
        end
        whole = sum >>> Q_FRAC;
        return (whole > 255) ? 8'd255 : whole[7:0];
    endfunction

    function automatic rgb_pixel_t luma_to_rgb(input logic [7:0] luma, input int db,
                                               input int dr);
        rgb_pixel_t px;
        int         base;
        base     = int'(luma) << Q_FRAC;
        px.red   = floor_to_byte(base + K_RED_CR * dr);
        px.green = floor_to_byte(base - K_GRN_CB * db - K_GRN_CR * dr);
        px.blue  = floor_to_byte(base + K_BLU_CB * db);
        return px;
    endfunction

    function automatic rgb_pair_t pair_to_rgb(input logic [7:0] y0, input logic [7:0] y1,
                                              input logic [7:0] cb, input logic [7:0] cr);
        rgb_pair_t pr;
        int        db;
        int        dr;
        db        = int'(cb) - MID_LEVEL;
        dr        = int'(cr) - MID_LEVEL;
        pr.first  = luma_to_rgb(y0, db, dr);
        pr.second = luma_to_rgb(y1, db, dr);
        return pr;
    endfunction

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Offer one request, holding it until accepted; returns at the accepting edge
    task automatic offer_pair(input logic [7:0] y0, input logic [7:0] y1,
                              input logic [7:0] cb, input logic [7:0] cr,
                              input bit typed, input rgb_pair_t rgb);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_luma_first  <= y0;
        s_luma_second <= y1;
        s_chroma_blue <= cb;
        s_chroma_red  <= cr;
        cur_typed     <= typed;
        cur_rgb       <= rgb;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rgb_expect_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_chroma();
        return ($urandom_range(0, 7) == 0) ? edge_levels[$urandom_range(0, 6)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !idle_on || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Scoreboard and watchdog; new request logged before any result is matched
    always @(posedge aclk) begin
        rgb_pair_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rgb_expect_q.push_back(cur_typed ? cur_rgb
                    : pair_to_rgb(s_luma_first, s_luma_second, s_chroma_blue, s_chroma_red));
            end
            if (m_valid && m_ready) begin
                if (rgb_expect_q.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    want = rgb_expect_q.pop_front();
                    check_channel("red_first",    want.first.red,    m_red_first);
                    check_channel("green_first",  want.first.green,  m_green_first);
                    check_channel("blue_first",   want.first.blue,   m_blue_first);
                    check_channel("red_second",   want.second.red,   m_red_second);
                    check_channel("green_second", want.second.green, m_green_second);
                    check_channel("blue_second",  want.second.blue,  m_blue_second);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (pair_table[i]) begin
            offer_pair(pair_table[i].luma_first, pair_table[i].luma_second,
                       pair_table[i].chroma_blue, pair_table[i].chroma_red,
                       pair_table[i].typed, pair_table[i].rgb);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                hold_req = 1'b1;
            end
            if (n == 600) begin
                wait_for_results();
            end
            // quiet stretch: neither side idles
            idle_on = !(n >= 700 && n < 900);
            offer_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       pick_chroma(), pick_chroma(), 1'b0, '0);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
